@@ rtl/core/ffha_pkg.sv @@
// Shared status codes and widths for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
   localparam int STATUS_W = 3;
   localparam int FIELD_W  = 12;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NULL    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd4;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [FIELD_W-1:0]  field_type;
endpackage

@@ rtl/core/ffha_hdr_ram.sv @@
// Block header memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module ffha_hdr_ram import ffha_pkg::*; #(
   parameter int DEPTH = 4096,
   parameter int DW    = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/first_fit_heap_allocator.sv @@
// First-fit heap allocator: header walk, split, frontier growth, free and merge.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_op, req_request_size, req_block_addr
//   rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_payload_addr
//
// Each visited block has its header read, then evaluated, through the read port
// of the header memory; a free that does not release the last used block then
// walks the whole chain again to merge.
// Reset is synchronous; the header memory needs no clearing pass.
// A stalled rsp holds the result; req is stalled until the result enters the rsp register.
`timescale 1ns / 1ps
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int HEAP_BYTES   = 4096,
   parameter int HEADER_BYTES = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  field_type  req_request_size,
   input  field_type  req_block_addr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output status_type rsp_status,
   output field_type  rsp_payload_addr
);
   localparam int AW = $clog2(HEAP_BYTES);
   localparam int FW = AW + 1;
   localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 2;
   localparam logic [CW-1:0] HB   = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] HEAP = CW'(HEAP_BYTES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_SPLIT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [1:0] M_ALLOC = 2'd0;
   localparam logic [1:0] M_FREE  = 2'd1;
   localparam logic [1:0] M_MERGE = 2'd2;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [FW-1:0] at_ff, at_in;
   logic [FW-1:0] frontier_ff, frontier_in;
   logic [AW-1:0] used_ff, used_in;
   field_type     req_ff, req_in;
   field_type     addr_ff, addr_in;
   logic [AW-1:0] run_ff, run_in;
   logic [AW-1:0] run_size_ff, run_size_in;
   logic          have_run_ff, have_run_in;
   logic [AW-1:0] split_at_ff, split_at_in;
   logic [AW-1:0] split_size_ff, split_size_in;
   status_type    res_status_ff, res_status_in;
   field_type     res_addr_ff, res_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   field_type     rsp_addr_ff, rsp_addr_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr;
   logic [AW:0]   wr_data, rd_data;

   logic          rd_used;
   logic [CW-1:0] at_c, sz_c, req_c, addr_c, next_c, fr_c, merged_c;

   ffha_hdr_ram #(.DEPTH(HEAP_BYTES), .DW(AW + 1)) u_hdr (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (at_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_used  = rd_data[AW];
   assign at_c     = CW'(at_ff);
   assign sz_c     = CW'(rd_data[AW-1:0]);
   assign req_c    = CW'(req_ff);
   assign addr_c   = CW'(addr_ff);
   assign fr_c     = CW'(frontier_ff);
   assign next_c   = at_c + HB + sz_c;
   assign merged_c = CW'(run_size_ff) + HB + sz_c;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      at_in         = at_ff;
      frontier_in   = frontier_ff;
      used_in       = used_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      run_in        = run_ff;
      run_size_in   = run_size_ff;
      have_run_in   = have_run_ff;
      split_at_in   = split_at_ff;
      split_size_in = split_size_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_request_size;
               addr_in     = req_block_addr;
               at_in       = FW'(1);
               res_addr_in = '0;
               if (!req_op) begin
                  mode_in = M_ALLOC;
                  if (req_request_size == '0) begin
                     res_status_in = STATUS_ZERO;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  mode_in = M_FREE;
                  if (req_block_addr == '0) begin
                     res_status_in = STATUS_NULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            if (at_ff < frontier_ff) begin
               rd_en    = 1'b1;
               state_in = S_EVAL;
            end else begin
               state_in = S_DONE;
               case (mode_ff)
                  M_ALLOC: begin
                     if (fr_c + HB + req_c > HEAP) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = frontier_ff[AW-1:0];
                        wr_data       = {1'b1, AW'(req_c)};
                        res_status_in = STATUS_OK;
                        res_addr_in   = FIELD_W'(fr_c + HB);
                        frontier_in   = FW'(fr_c + HB + req_c);
                        used_in       = used_ff + AW'(1);
                     end
                  end
                  M_FREE:  res_status_in = STATUS_INVALID;
                  default: res_status_in = STATUS_OK;
               endcase
            end
         end
         S_EVAL: begin
            state_in = S_READ;
            at_in    = FW'(next_c);
            case (mode_ff)
               M_ALLOC: begin
                  if (!rd_used && (req_c + HB + CW'(1) <= sz_c)) begin
                     wr_en         = 1'b1;
                     wr_addr       = at_ff[AW-1:0];
                     wr_data       = {1'b1, AW'(req_c)};
                     split_at_in   = AW'(at_c + HB + req_c);
                     split_size_in = AW'(sz_c - req_c - HB);
                     res_status_in = STATUS_OK;
                     res_addr_in   = FIELD_W'(at_c + HB);
                     state_in      = S_SPLIT;
                  end
               end
               M_FREE: begin
                  if (at_c + HB == addr_c) begin
                     state_in = S_DONE;
                     if (!rd_used) begin
                        res_status_in = STATUS_INVALID;
                     end else begin
                        res_status_in = STATUS_OK;
                        wr_en         = 1'b1;
                        wr_addr       = at_ff[AW-1:0];
                        wr_data       = {1'b0, rd_data[AW-1:0]};
                        if (used_ff == AW'(1)) begin
                           used_in     = '0;
                           frontier_in = FW'(1);
                        end else begin
                           used_in     = used_ff - AW'(1);
                           mode_in     = M_MERGE;
                           at_in       = FW'(1);
                           have_run_in = 1'b0;
                           state_in    = S_READ;
                        end
                     end
                  end else if (at_c + HB > addr_c) begin
                     res_status_in = STATUS_INVALID;
                     state_in      = S_DONE;
                  end
               end
               default: begin
                  if (rd_used) begin
                     have_run_in = 1'b0;
                  end else if (!have_run_ff) begin
                     run_in      = at_ff[AW-1:0];
                     run_size_in = rd_data[AW-1:0];
                     have_run_in = 1'b1;
                  end else begin
                     run_size_in = AW'(merged_c);
                     wr_en       = 1'b1;
                     wr_addr     = run_ff;
                     wr_data     = {1'b0, AW'(merged_c)};
                  end
               end
            endcase
         end
         S_SPLIT: begin
            wr_en    = 1'b1;
            wr_addr  = split_at_ff;
            wr_data  = {1'b0, split_size_ff};
            used_in  = used_ff + AW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frontier_ff  <= FW'(1);
         used_ff      <= '0;
         have_run_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frontier_ff  <= frontier_in;
         used_ff      <= used_in;
         have_run_ff  <= have_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      at_ff         <= at_in;
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      run_ff        <= run_in;
      run_size_ff   <= run_size_in;
      split_at_ff   <= split_at_in;
      split_size_ff <= split_size_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_addr = rsp_addr_ff;
endmodule
